>>> hw/rtl/mpsp_pkg.sv
// package for the mac pdu subheader parser
// holds shared constants, parse phase and result kind codes, result structs
// no dependencies
`timescale 1ns / 1ps

package mpsp_pkg;

   localparam int LENGTH_WIDTH = 16;
   localparam int LCID_WIDTH   = 6;
   localparam int BYTE_WIDTH   = 8;

   localparam logic [BYTE_WIDTH-1:0] LCID_MASK = 8'h3F;
   localparam logic [BYTE_WIDTH-1:0] F_BIT     = 8'h40;

   localparam logic [LCID_WIDTH-1:0] PADDING_LCID_RESET = 6'd63;

   typedef enum logic [2:0] {
      PH_SUBHDR  = 3'd0,
      PH_LEN_HI  = 3'd1,
      PH_LEN_LO  = 3'd2,
      PH_PAYLOAD = 3'd3,
      PH_SKIP    = 3'd4
   } phase_type;

   typedef enum logic [1:0] {
      KIND_DATA  = 2'd0,
      KIND_EMPTY = 2'd1,
      KIND_ABORT = 2'd2
   } kind_type;

   typedef struct packed {
      kind_type                  kind;
      logic [LCID_WIDTH-1:0]     channel_id;
      logic [BYTE_WIDTH-1:0]     payload;
      logic                      sdu_first;
      logic                      sdu_last;
      logic                      run_last;
   } result_type;

   // up to two results per request, second only together with the first
   typedef struct packed {
      logic       push0;
      logic       push1;
      result_type res0;
      result_type res1;
   } emit_type;

endpackage

>>> hw/rtl/mpsp_ifs.sv
// channel interfaces of the mac pdu subheader parser: request, response, csr
// depends on mpsp_pkg
`timescale 1ns / 1ps

interface mpsp_req_if;
   logic                             valid;
   logic                             ready;
   logic [mpsp_pkg::BYTE_WIDTH-1:0]  pdu_byte;
   logic                             pdu_end;

   modport source (output valid, output pdu_byte, output pdu_end, input ready);
   modport sink   (input valid, input pdu_byte, input pdu_end, output ready);
endinterface

interface mpsp_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [1:0]                       kind;
   logic [mpsp_pkg::LCID_WIDTH-1:0]  channel_id;
   logic [mpsp_pkg::BYTE_WIDTH-1:0]  payload;
   logic                             sdu_first;
   logic                             sdu_last;
   logic                             run_last;

   modport source (output valid, output kind, output channel_id, output payload,
                   output sdu_first, output sdu_last, output run_last, input ready);
   modport sink   (input valid, input kind, input channel_id, input payload,
                   input sdu_first, input sdu_last, input run_last, output ready);
endinterface

interface mpsp_csr_if;
   logic                             valid;
   logic                             ready;
   logic [mpsp_pkg::LCID_WIDTH-1:0]  padding_lcid;

   modport source (output valid, output padding_lcid, input ready);
   modport sink   (input valid, input padding_lcid, output ready);
endinterface

>>> hw/rtl/mpsp_parser.sv
// subheader / length / payload parse state and result generation
// depends on mpsp_pkg
`timescale 1ns / 1ps

module mpsp_parser (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             accept,
   input  logic [mpsp_pkg::BYTE_WIDTH-1:0]  pdu_byte,
   input  logic                             pdu_end,
   input  logic [mpsp_pkg::LCID_WIDTH-1:0]  padding_lcid,
   output mpsp_pkg::emit_type               emit
);

   mpsp_pkg::phase_type                     phase_ff, phase_in;
   logic [mpsp_pkg::LCID_WIDTH-1:0]         channel_ff, channel_in;
   logic                                    two_byte_ff, two_byte_in;
   logic [mpsp_pkg::BYTE_WIDTH-1:0]         len_high_ff, len_high_in;
   logic [mpsp_pkg::LENGTH_WIDTH-1:0]       remaining_ff, remaining_in;
   logic                                    first_ff, first_in;

   logic [mpsp_pkg::LCID_WIDTH-1:0]         lcid;
   logic [2*mpsp_pkg::BYTE_WIDTH-1:0]       len_full;
   logic [mpsp_pkg::LENGTH_WIDTH-1:0]       len;
   logic [mpsp_pkg::LENGTH_WIDTH-1:0]       remaining_dec;

   assign lcid          = mpsp_pkg::LCID_WIDTH'(pdu_byte & mpsp_pkg::LCID_MASK);
   assign len_full      = two_byte_ff ? {len_high_ff, pdu_byte}
                                      : {{mpsp_pkg::BYTE_WIDTH{1'b0}}, pdu_byte};
   assign len           = len_full[mpsp_pkg::LENGTH_WIDTH-1:0];
   assign remaining_dec = remaining_ff - mpsp_pkg::LENGTH_WIDTH'(1);

   always_comb begin
      phase_in     = phase_ff;
      channel_in   = channel_ff;
      two_byte_in  = two_byte_ff;
      len_high_in  = len_high_ff;
      remaining_in = remaining_ff;
      first_in     = first_ff;
      emit         = '0;
      emit.res0.channel_id = channel_ff;
      emit.res1.channel_id = channel_ff;
      emit.res1.kind       = mpsp_pkg::KIND_ABORT;

      if (accept) begin
         case (phase_ff)
            mpsp_pkg::PH_LEN_HI: begin
               len_high_in = pdu_byte;
               phase_in    = mpsp_pkg::PH_LEN_LO;
            end
            mpsp_pkg::PH_LEN_LO: begin
               if (len == '0) begin
                  emit.push0          = 1'b1;
                  emit.res0.kind      = mpsp_pkg::KIND_EMPTY;
                  emit.res0.sdu_first = 1'b1;
                  emit.res0.sdu_last  = 1'b1;
                  emit.res0.run_last  = 1'b1;
                  phase_in            = mpsp_pkg::PH_SUBHDR;
               end else begin
                  remaining_in = len;
                  first_in     = 1'b1;
                  phase_in     = mpsp_pkg::PH_PAYLOAD;
               end
            end
            mpsp_pkg::PH_PAYLOAD: begin
               emit.push0          = 1'b1;
               emit.res0.kind      = mpsp_pkg::KIND_DATA;
               emit.res0.payload   = pdu_byte;
               emit.res0.sdu_first = first_ff;
               emit.res0.sdu_last  = (remaining_dec == '0);
               first_in            = 1'b0;
               remaining_in        = remaining_dec;
               if (remaining_dec == '0) begin
                  emit.res0.run_last = 1'b1;
                  phase_in           = mpsp_pkg::PH_SUBHDR;
               end else if (pdu_end) begin
                  // pdu ended inside the payload: follow with an abort
                  emit.push1         = 1'b1;
                  emit.res1.run_last = 1'b1;
               end else begin
                  emit.res0.run_last = 1'b1;
               end
            end
            mpsp_pkg::PH_SKIP: begin
               phase_in = mpsp_pkg::PH_SKIP;
            end
            default: begin
               // subheader, unused codes land here too
               if (!pdu_end) begin
                  if (lcid == padding_lcid) begin
                     phase_in = mpsp_pkg::PH_SKIP;
                  end else begin
                     channel_in  = lcid;
                     two_byte_in = ((pdu_byte & mpsp_pkg::F_BIT) != '0);
                     phase_in    = two_byte_in ? mpsp_pkg::PH_LEN_HI : mpsp_pkg::PH_LEN_LO;
                  end
               end
            end
         endcase
         if (pdu_end) begin
            phase_in = mpsp_pkg::PH_SUBHDR;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= mpsp_pkg::PH_SUBHDR;
         channel_ff   <= '0;
         two_byte_ff  <= 1'b0;
         len_high_ff  <= '0;
         remaining_ff <= '0;
         first_ff     <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         channel_ff   <= channel_in;
         two_byte_ff  <= two_byte_in;
         len_high_ff  <= len_high_in;
         remaining_ff <= remaining_in;
         first_ff     <= first_in;
      end
   end

endmodule

>>> hw/rtl/mpsp_rsp_queue.sv
// four-entry result queue, takes one or two results per cycle, gives one while out_ready is high
// depends on mpsp_pkg
`timescale 1ns / 1ps

module mpsp_rsp_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  mpsp_pkg::emit_type   emit,
   output logic                 room,
   output logic                 out_valid,
   input  logic                 out_ready,
   output mpsp_pkg::result_type out_data
);

   mpsp_pkg::result_type entry_ff [4];
   mpsp_pkg::result_type entry_in [4];
   logic [1:0]           head_ff, head_in;
   logic [1:0]           tail_ff, tail_in;
   logic [2:0]           count_ff, count_in;
   logic                 pop;
   logic [1:0]           tail_next;

   assign out_valid = (count_ff != 3'd0);
   assign out_data  = entry_ff[head_ff];
   // room for the two results a request may cause
   assign room      = (count_ff <= 3'd2);
   assign pop       = out_valid && out_ready;
   assign tail_next = tail_ff + 2'd1;

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         entry_in[i] = entry_ff[i];
      end
      tail_in = tail_ff;
      if (emit.push0) begin
         entry_in[tail_ff] = emit.res0;
         tail_in           = tail_next;
      end
      if (emit.push0 && emit.push1) begin
         entry_in[tail_next] = emit.res1;
         tail_in             = tail_ff + 2'd2;
      end
      head_in  = pop ? head_ff + 2'd1 : head_ff;
      count_in = count_ff + 3'(emit.push0) + 3'(emit.push0 && emit.push1) - 3'(pop);
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 4; i++) begin
         entry_ff[i] <= entry_in[i];
      end
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

endmodule

>>> hw/rtl/mac_pdu_subheader_parser_core.sv
// top level of the mac pdu subheader parser
// depends on mpsp_pkg, mpsp_ifs, mpsp_parser, mpsp_rsp_queue
`timescale 1ns / 1ps

// Usage
//   req_ch: one received mac pdu byte per request, pdu_end marks the last byte.
//   rsp_ch: sdu results: payload bytes tagged with lcid and first/last marks,
//           empty-sdu results and abort results for a payload cut short.
//   csr_ch: writes padding_lcid; always ready, write only while idle.
// Results: the results of an accepted request are registered in the result
//   queue and leave it on rsp_ch after any older queued results.
// Throughput: one request per cycle while req_ch is ready. A request gives
//   zero, one or two results; two only for a payload byte that ends the pdu
//   early. The four-entry result queue sets the pace: req_ch is ready while
//   the queue holds at most two results, and a byte that makes two results
//   leaves the queue on rsp_ch one result at a time.
// Reset: parser waits for a subheader byte, queue empties, padding_lcid = 63.
// Stall: when rsp_ch is not ready results collect in the queue, and req_ch
//   drops ready once fewer than two slots are free; nothing is lost.

module mac_pdu_subheader_parser_core (
   input  logic        clock,
   input  logic        reset,
   mpsp_req_if.sink    req_ch,
   mpsp_rsp_if.source  rsp_ch,
   mpsp_csr_if.sink    csr_ch
);

   logic [mpsp_pkg::LCID_WIDTH-1:0] padding_lcid_ff, padding_lcid_in;
   logic                            room;
   logic                            accept;
   mpsp_pkg::emit_type              emit;
   mpsp_pkg::result_type            rsp_data;

   assign csr_ch.ready    = 1'b1;
   assign padding_lcid_in = csr_ch.valid ? csr_ch.padding_lcid : padding_lcid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         padding_lcid_ff <= mpsp_pkg::PADDING_LCID_RESET;
      end else begin
         padding_lcid_ff <= padding_lcid_in;
      end
   end

   assign req_ch.ready = room;
   assign accept       = req_ch.valid && room;

   mpsp_parser u_parser (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .pdu_byte     (req_ch.pdu_byte),
      .pdu_end      (req_ch.pdu_end),
      .padding_lcid (padding_lcid_ff),
      .emit         (emit)
   );

   mpsp_rsp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .emit      (emit),
      .room      (room),
      .out_valid (rsp_ch.valid),
      .out_ready (rsp_ch.ready),
      .out_data  (rsp_data)
   );

   assign rsp_ch.kind       = rsp_data.kind;
   assign rsp_ch.channel_id = rsp_data.channel_id;
   assign rsp_ch.payload    = rsp_data.payload;
   assign rsp_ch.sdu_first  = rsp_data.sdu_first;
   assign rsp_ch.sdu_last   = rsp_data.sdu_last;
   assign rsp_ch.run_last   = rsp_data.run_last;

endmodule

>>> tb/mac_pdu_subheader_parser_core_tb.sv
// testbench for mac_pdu_subheader_parser_core: directed and random mac pdus,
// results checked against an in-bench parser model, random idling on both sides
// depends on mpsp_pkg, mpsp_ifs and the rtl of the parser core
`timescale 1ns / 1ps

module mac_pdu_subheader_parser_core_tb;

   localparam int QUIET_LIMIT = 2000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   mpsp_req_if req_ch ();
   mpsp_rsp_if rsp_ch ();
   mpsp_csr_if csr_ch ();

   mac_pdu_subheader_parser_core dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // parser model state
   mpsp_pkg::phase_type                 phase_m;
   logic [mpsp_pkg::LCID_WIDTH-1:0]     channel_m;
   logic                                two_byte_m;
   logic [mpsp_pkg::BYTE_WIDTH-1:0]     len_high_m;
   logic [mpsp_pkg::LENGTH_WIDTH-1:0]   remaining_m;
   logic                                first_m;
   logic [mpsp_pkg::LCID_WIDTH-1:0]     padding_m;

   mpsp_pkg::result_type sdu_results_due[$];
   int         error_count = 0;
   int         bytes_sent = 0;
   int         quiet_cycles;
   bit         send_idle = 1'b1;
   bit         rsp_idle = 1'b1;

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic mpsp_pkg::result_type make_result(
         input mpsp_pkg::kind_type k,
         input logic [mpsp_pkg::LCID_WIDTH-1:0] ch,
         input logic [mpsp_pkg::BYTE_WIDTH-1:0] d,
         input logic f, input logic l);
      mpsp_pkg::result_type r;
      r.kind       = k;
      r.channel_id = ch;
      r.payload    = d;
      r.sdu_first  = f;
      r.sdu_last   = l;
      r.run_last   = 1'b0;
      return r;
   endfunction

   // append one prediction at the tail of the expected results
   function automatic void add_due(input mpsp_pkg::result_type r);
      sdu_results_due.insert(sdu_results_due.size(), r);
   endfunction

   task automatic parse_pdu_byte(input logic [mpsp_pkg::BYTE_WIDTH-1:0] b,
                                 input logic last_byte);
      logic [mpsp_pkg::LENGTH_WIDTH-1:0] len;
      mpsp_pkg::result_type              res [2];
      int                                n;
      n = 0;
      case (phase_m)
         mpsp_pkg::PH_LEN_HI: begin
            len_high_m = b;
            phase_m = mpsp_pkg::PH_LEN_LO;
         end
         mpsp_pkg::PH_LEN_LO: begin
            len = two_byte_m ? {len_high_m, b} : mpsp_pkg::LENGTH_WIDTH'(b);
            if (len == 0) begin
               res[n] = make_result(mpsp_pkg::KIND_EMPTY, channel_m, 8'h00, 1'b1, 1'b1);
               n++;
               phase_m = mpsp_pkg::PH_SUBHDR;
            end else begin
               remaining_m = len;
               first_m = 1'b1;
               phase_m = mpsp_pkg::PH_PAYLOAD;
            end
         end
         mpsp_pkg::PH_PAYLOAD: begin
            res[n] = make_result(mpsp_pkg::KIND_DATA, channel_m, b, first_m,
                                 remaining_m == 1);
            n++;
            first_m = 1'b0;
            remaining_m = remaining_m - 1'b1;
            if (remaining_m == 0) begin
               phase_m = mpsp_pkg::PH_SUBHDR;
            end else if (last_byte) begin
               // pdu ended inside the payload
               res[n] = make_result(mpsp_pkg::KIND_ABORT, channel_m, 8'h00, 1'b0, 1'b0);
               n++;
            end
         end
         mpsp_pkg::PH_SKIP: begin
         end
         default: begin
            if (!last_byte) begin
               if (b[mpsp_pkg::LCID_WIDTH-1:0] == padding_m) begin
                  phase_m = mpsp_pkg::PH_SKIP;
               end else begin
                  channel_m = b[mpsp_pkg::LCID_WIDTH-1:0];
                  two_byte_m = ((b & mpsp_pkg::F_BIT) != '0);
                  phase_m = two_byte_m ? mpsp_pkg::PH_LEN_HI : mpsp_pkg::PH_LEN_LO;
               end
            end
         end
      endcase
      if (last_byte) begin
         phase_m = mpsp_pkg::PH_SUBHDR;
      end
      if (n > 0) begin
         res[n-1].run_last = 1'b1;
      end
      for (int i = 0; i < n; i++) begin
         add_due(res[i]);
      end
   endtask

   task automatic send_byte(input logic [mpsp_pkg::BYTE_WIDTH-1:0] b, input logic last_byte);
      int gap;
      gap = send_idle ? $urandom_range(0, 14) : 0;
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid    <= 1'b1;
      req_ch.pdu_byte <= b;
      req_ch.pdu_end  <= last_byte;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      parse_pdu_byte(b, last_byte);
      bytes_sent++;
   endtask

   task automatic send_bytes(input logic [mpsp_pkg::BYTE_WIDTH-1:0] bytes[$],
                             input bit ends_pdu);
      foreach (bytes[i]) begin
         send_byte(bytes[i], ends_pdu && (i == bytes.size() - 1));
      end
   endtask

   // stop sending and let every pending result drain out
   task automatic wait_idle();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (sdu_results_due.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_padding(input logic [mpsp_pkg::LCID_WIDTH-1:0] value);
      csr_ch.valid        <= 1'b1;
      csr_ch.padding_lcid <= value;
      do @(posedge clock); while (csr_ch.ready !== 1'b1);
      padding_m = value;
      csr_ch.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic test_directed_cases();
      send_bytes('{8'h01, 8'h02, 8'hFF, 8'h00}, 1'b0);     // one-byte length, two bytes
      send_bytes('{8'hC0, 8'h00, 8'h01, 8'hAA}, 1'b0);     // reserved bit, two-byte length
      send_bytes('{8'h3E, 8'h00}, 1'b0);                   // zero length
      send_bytes('{8'h3F, 8'h55, 8'h66}, 1'b1);            // padding skips the rest
      send_bytes('{8'h02}, 1'b1);                          // subheader cut off
      send_bytes('{8'h44, 8'h12}, 1'b1);                   // length cut off
      send_bytes('{8'h07, 8'h00}, 1'b1);                   // zero length on the last byte
      send_bytes('{8'h08, 8'h05}, 1'b1);                   // length on the last byte
      send_bytes('{8'h09, 8'h03, 8'h11, 8'h22}, 1'b1);     // payload cut short
   endtask

   // sender holds off in the middle of an sdu until all results are out
   task automatic test_pause_mid_sdu();
      send_bytes('{8'h0A, 8'h04, 8'h5A, 8'hA5}, 1'b0);
      wait_idle();
      send_bytes('{8'h0F, 8'hF0}, 1'b1);
   endtask

   task automatic send_random_pdu();
      logic [mpsp_pkg::BYTE_WIDTH-1:0] pdu[$];
      logic [mpsp_pkg::LCID_WIDTH-1:0] lcid;
      logic                            two;
      logic                            rsv;
      int                              style;
      int                              len;
      int                              n_sdu;
      style = $urandom_range(0, 99);
      if (style < 10) begin
         repeat ($urandom_range(1, 12)) pdu = {pdu, 8'($urandom_range(0, 255))};
      end else begin
         n_sdu = $urandom_range(1, 4);
         for (int i = 0; i < n_sdu; i++) begin
            lcid = ($urandom_range(0, 7) == 0) ? padding_m
                                               : mpsp_pkg::LCID_WIDTH'($urandom_range(0, 63));
            two  = 1'($urandom_range(0, 1));
            rsv  = 1'($urandom_range(0, 1));
            pdu = {pdu, {rsv, two, lcid}};
            if (lcid == padding_m) begin
               repeat ($urandom_range(0, 6)) pdu = {pdu, 8'($urandom_range(0, 255))};
               break;
            end
            len = ($urandom_range(0, 15) == 0) ? $urandom_range(0, two ? 65535 : 255)
                                               : $urandom_range(0, 6);
            if (two) begin
               pdu = {pdu, len[15:8]};
            end
            pdu = {pdu, len[7:0]};
            if (len > 24) begin
               // long sdu: only its start is sent, the pdu ends early
               repeat ($urandom_range(1, 24)) pdu = {pdu, 8'($urandom_range(0, 255))};
               break;
            end
            repeat (len) pdu = {pdu, 8'($urandom_range(0, 255))};
         end
         if (style < 25) begin
            pdu = pdu[0:$urandom_range(0, pdu.size() - 1)];
         end
      end
      send_bytes(pdu, 1'b1);
   endtask

   task automatic test_random_pdus(input logic [mpsp_pkg::LCID_WIDTH-1:0] pad,
                                   input int n_bytes,
                                   input bit sender_idles, input bit receiver_idles);
      int stop_at;
      wait_idle();
      write_padding(pad);
      send_idle = sender_idles;
      rsp_idle  = receiver_idles;
      stop_at = bytes_sent + n_bytes;
      while (bytes_sent < stop_at) begin
         send_random_pdu();
      end
   endtask

   task automatic check_field(input string name, input logic [mpsp_pkg::BYTE_WIDTH-1:0] want,
                              input logic [mpsp_pkg::BYTE_WIDTH-1:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         error_count++;
      end
   endtask

   // response side: random stalls, compare each result with the oldest prediction
   initial begin
      mpsp_pkg::result_type want;
      int                   stall;
      rsp_ch.ready <= 1'b0;
      wait (reset == 1'b0);
      forever begin
         stall = rsp_idle ? $urandom_range(0, 14) : 0;
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (rsp_ch.valid !== 1'b1);
         if (sdu_results_due.size() == 0) begin
            $error("unexpected result: kind %0d channel_id %0d payload %0d",
                   rsp_ch.kind, rsp_ch.channel_id, rsp_ch.payload);
            error_count++;
         end else begin
            want = sdu_results_due.pop_front();
            check_field("kind", 8'(want.kind), 8'(rsp_ch.kind));
            check_field("channel_id", 8'(want.channel_id), 8'(rsp_ch.channel_id));
            check_field("payload", want.payload, rsp_ch.payload);
            check_field("sdu_first", 8'(want.sdu_first), 8'(rsp_ch.sdu_first));
            check_field("sdu_last", 8'(want.sdu_last), 8'(rsp_ch.sdu_last));
            check_field("run_last", 8'(want.run_last), 8'(rsp_ch.run_last));
         end
      end
   end

   // watchdog on cycles with no handshake on any channel
   initial begin
      quiet_cycles = 0;
      while (quiet_cycles < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
             (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) ||
             (csr_ch.valid === 1'b1 && csr_ch.ready === 1'b1)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
      end
      $display("status: fail");
      $finish;
   end

   initial begin
      req_ch.valid        <= 1'b0;
      req_ch.pdu_byte     <= '0;
      req_ch.pdu_end      <= 1'b0;
      csr_ch.valid        <= 1'b0;
      csr_ch.padding_lcid <= '0;
      phase_m     = mpsp_pkg::PH_SUBHDR;
      channel_m   = '0;
      two_byte_m  = 1'b0;
      len_high_m  = '0;
      remaining_m = '0;
      first_m     = 1'b0;
      padding_m   = mpsp_pkg::PADDING_LCID_RESET;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_cases();
      test_pause_mid_sdu();
      test_random_pdus(6'd0, 250, 1'b1, 1'b1);
      test_random_pdus(6'd63, 250, 1'b0, 1'b0);
      test_random_pdus(mpsp_pkg::LCID_WIDTH'($urandom_range(1, 62)), 250, 1'b0, 1'b1);
      test_random_pdus(mpsp_pkg::LCID_WIDTH'($urandom_range(1, 62)), 250, 1'b1, 1'b0);
      test_random_pdus(6'd0, 250, 1'b0, 1'b0);
      test_random_pdus(6'd63, 250, 1'b1, 1'b1);

      req_ch.valid <= 1'b0;
      do @(posedge clock); while (sdu_results_due.size() != 0);
      repeat (8) @(posedge clock);
      if (sdu_results_due.size() != 0) begin
         $error("%0d results never arrived", sdu_results_due.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
